// File: rtl/cbz_pkg.sv
// Shared constants, register codes and types for the cubic Bezier plotter.
package cbz_pkg;

   localparam int COORD_BITS_DEF  = 10;
   localparam int T_FRAC_BITS_DEF = 12;

   localparam int PIX_BITS      = 12;
   localparam int INTEN_BITS    = 8;
   localparam int RSP_DATA_BITS = 2 * PIX_BITS + INTEN_BITS;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_BITS  = 3;

   // Register indexes of the control point coordinates.
   localparam logic [REG_IDX_BITS-1:0] REG_P0_X = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_P0_Y = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_P1_X = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_P1_Y = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_P2_X = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_P2_Y = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_P3_X = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_P3_Y = 3'd7;

   // 255 squared: scales the squared distance before the root.
   localparam int GAIN_BITS = 16;
   localparam logic [GAIN_BITS-1:0]  INTEN_GAIN = 16'd65025;
   localparam logic [INTEN_BITS-1:0] INTEN_FULL = 8'd255;

   // Pixel addresses of one point: its own pixel and the nearer neighbors.
   typedef struct packed {
      logic [PIX_BITS-1:0] ix;
      logic [PIX_BITS-1:0] iy;
      logic [PIX_BITS-1:0] nx;
      logic [PIX_BITS-1:0] ny;
   } pix_set_type;

endpackage

// File: rtl/cbz_curve.sv
// De Casteljau evaluation pipeline: three lerp levels, each a multiply and an add stage.
module cbz_curve #(
   parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [T_FRAC_BITS:0]              in_t,
   input  logic [COORD_BITS-1:0]             cp_x [4],
   input  logic [COORD_BITS-1:0]             cp_y [4],
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [COORD_BITS+T_FRAC_BITS-1:0] out_px,
   output logic [COORD_BITS+T_FRAC_BITS-1:0] out_py
);

   localparam int F   = T_FRAC_BITS;
   localparam int TW  = F + 1;
   localparam int P   = COORD_BITS + F;
   localparam int MW  = TW + P + 2;
   localparam int NST = 7;

   localparam logic [TW-1:0] T_ONE  = TW'(1) << F;
   localparam logic [MW-1:0] HALF_W = MW'(1) << (F - 1);

   // Signed t*(a-b); the result width carries the full product.
   function automatic logic signed [MW-1:0] lerp_mul(input logic [TW-1:0] t,
                                                     input logic [P-1:0]  a,
                                                     input logic [P-1:0]  b);
      logic signed [TW:0] ts;
      logic signed [P:0]  d;
      ts = signed'({1'b0, t});
      d  = signed'({1'b0, a}) - signed'({1'b0, b});
      lerp_mul = ts * d;
   endfunction

   // (b*S + t*(a-b) + S/2) >> F, always non-negative and below 2^P.
   function automatic logic [P-1:0] lerp_add(input logic [P-1:0]         b,
                                             input logic signed [MW-1:0] prod);
      logic signed [MW-1:0] s;
      s = signed'(MW'({b, {F{1'b0}}})) + prod + signed'(HALF_W);
      lerp_add = s[P+F-1:F];
   endfunction

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_src;
   logic [NST:0]   rdy;

   logic [TW-1:0]        t0_in, t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic [P-1:0]         pt0 [2][4];
   logic signed [MW-1:0] prod1_in [2][3], prod1_ff [2][3];
   logic [P-1:0]         b1_in [2][3], b1_ff [2][3];
   logic [P-1:0]         sum1_in [2][3], sum1_ff [2][3];
   logic signed [MW-1:0] prod2_in [2][2], prod2_ff [2][2];
   logic [P-1:0]         b2_in [2][2], b2_ff [2][2];
   logic [P-1:0]         sum2_in [2][2], sum2_ff [2][2];
   logic signed [MW-1:0] prod3_in [2], prod3_ff [2];
   logic [P-1:0]         b3_in [2], b3_ff [2];
   logic [P-1:0]         sum3_in [2], sum3_ff [2];

   always_comb begin
      rdy[NST] = out_ready;
      for (int i = NST - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign v_src     = {v_ff[NST-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   always_comb begin
      t0_in = (in_t > T_ONE) ? T_ONE : in_t;
      for (int k = 0; k < 4; k++) begin
         pt0[0][k] = {cp_x[k], {F{1'b0}}};
         pt0[1][k] = {cp_y[k], {F{1'b0}}};
      end
      for (int l = 0; l < 2; l++) begin
         for (int k = 0; k < 3; k++) begin
            prod1_in[l][k] = lerp_mul(t0_ff, pt0[l][k], pt0[l][k+1]);
            b1_in[l][k]    = pt0[l][k+1];
            sum1_in[l][k]  = lerp_add(b1_ff[l][k], prod1_ff[l][k]);
         end
         for (int k = 0; k < 2; k++) begin
            prod2_in[l][k] = lerp_mul(t2_ff, sum1_ff[l][k], sum1_ff[l][k+1]);
            b2_in[l][k]    = sum1_ff[l][k+1];
            sum2_in[l][k]  = lerp_add(b2_ff[l][k], prod2_ff[l][k]);
         end
         prod3_in[l] = lerp_mul(t4_ff, sum2_ff[l][0], sum2_ff[l][1]);
         b3_in[l]    = sum2_ff[l][1];
         sum3_in[l]  = lerp_add(b3_ff[l], prod3_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         t0_ff <= t0_in;
      end
      if (rdy[1]) begin
         t1_ff    <= t0_ff;
         prod1_ff <= prod1_in;
         b1_ff    <= b1_in;
      end
      if (rdy[2]) begin
         t2_ff   <= t1_ff;
         sum1_ff <= sum1_in;
      end
      if (rdy[3]) begin
         t3_ff    <= t2_ff;
         prod2_ff <= prod2_in;
         b2_ff    <= b2_in;
      end
      if (rdy[4]) begin
         t4_ff   <= t3_ff;
         sum2_ff <= sum2_in;
      end
      if (rdy[5]) begin
         prod3_ff <= prod3_in;
         b3_ff    <= b3_in;
      end
      if (rdy[6]) begin
         sum3_ff <= sum3_in;
      end
   end

   assign out_px = sum3_ff[0];
   assign out_py = sum3_ff[1];

endmodule

// File: rtl/cbz_dist.sv
// Pixel split, neighbor choice and scaled squared distance to the pixel center.
module cbz_dist #(
   parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_px,
   input  logic [COORD_BITS+T_FRAC_BITS-1:0] in_py,
   output logic                              out_valid,
   input  logic                              out_ready,
   output cbz_pkg::pix_set_type              out_set,
   output logic [2*T_FRAC_BITS+15:0]         out_w
);

   localparam int F   = T_FRAC_BITS;
   localparam int P   = COORD_BITS + F;
   localparam int QW  = 2 * F;
   localparam int W   = 2 * F + cbz_pkg::GAIN_BITS;
   localparam int NST = 3;
   localparam int PB  = cbz_pkg::PIX_BITS;

   localparam logic [F-1:0]  HALF    = F'(1) << (F - 1);
   localparam logic [PB-1:0] PIX_ONE = PB'(1);

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_src;
   logic [NST:0]   rdy;

   logic [F-1:0]         fx, fy;
   cbz_pkg::pix_set_type set0_in, set0_ff, set1_ff, set2_ff;
   logic [F-1:0]         adx_in, ady_in, adx_ff, ady_ff;
   logic [QW-1:0]        q_in, q_ff;
   logic [W-1:0]         w_in, w_ff;

   always_comb begin
      rdy[NST] = out_ready;
      for (int i = NST - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign v_src     = {v_ff[NST-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   // The step goes up only when the fraction is strictly above one half.
   always_comb begin
      fx         = in_px[F-1:0];
      fy         = in_py[F-1:0];
      set0_in.ix = PB'(in_px[P-1:F]);
      set0_in.iy = PB'(in_py[P-1:F]);
      set0_in.nx = (fx > HALF) ? set0_in.ix + PIX_ONE : set0_in.ix - PIX_ONE;
      set0_in.ny = (fy > HALF) ? set0_in.iy + PIX_ONE : set0_in.iy - PIX_ONE;
      adx_in     = (fx >= HALF) ? fx - HALF : HALF - fx;
      ady_in     = (fy >= HALF) ? fy - HALF : HALF - fy;
      q_in       = adx_ff * adx_ff + ady_ff * ady_ff;
      w_in       = q_ff * cbz_pkg::INTEN_GAIN;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         set0_ff <= set0_in;
         adx_ff  <= adx_in;
         ady_ff  <= ady_in;
      end
      if (rdy[1]) begin
         set1_ff <= set0_ff;
         q_ff    <= q_in;
      end
      if (rdy[2]) begin
         set2_ff <= set1_ff;
         w_ff    <= w_in;
      end
   end

   assign out_set = set2_ff;
   assign out_w   = w_ff;

endmodule

// File: rtl/cbz_root.sv
// Pipelined integer square roots of w and w/2, two result bits per stage.
module cbz_root #(
   parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  cbz_pkg::pix_set_type      in_set,
   input  logic [2*T_FRAC_BITS+15:0] in_w,
   output logic                      out_valid,
   input  logic                      out_ready,
   output cbz_pkg::pix_set_type      out_set,
   output logic [T_FRAC_BITS+7:0]    out_ortho,
   output logic [T_FRAC_BITS+7:0]    out_diag
);

   localparam int W  = 2 * T_FRAC_BITS + cbz_pkg::GAIN_BITS;
   localparam int RW = W / 2;
   localparam int NS = (RW + 1) / 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS:0]   rdy;

   logic [W-1:0]         rad_in  [NS][2], rad_ff  [NS][2];
   logic [RW+1:0]        rem_in  [NS][2], rem_ff  [NS][2];
   logic [RW-1:0]        root_in [NS][2], root_ff [NS][2];
   cbz_pkg::pix_set_type set_ff  [NS];

   always_comb begin
      rdy[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   assign v_src     = {v_ff[NS-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_src[i];
            end
         end
      end
   end

   // Restoring digit recurrence: bring down two radicand bits, try 4q+1 with q the partial root.
   always_comb begin
      logic [W-1:0]  r;
      logic [RW+1:0] m;
      logic [RW+1:0] mn;
      logic [RW+1:0] tr;
      logic [RW-1:0] q;
      for (int s = 0; s < NS; s++) begin
         for (int l = 0; l < 2; l++) begin
            if (s == 0) begin
               r = (l == 0) ? in_w : (in_w >> 1);
               m = '0;
               q = '0;
            end else begin
               r = rad_ff[s-1][l];
               m = rem_ff[s-1][l];
               q = root_ff[s-1][l];
            end
            for (int j = 0; j < 2; j++) begin
               if (2 * s + j < RW) begin
                  mn = {m[RW-1:0], r[W-1:W-2]};
                  r  = r << 2;
                  tr = {q, 2'b01};
                  if (mn >= tr) begin
                     m = mn - tr;
                     q = {q[RW-2:0], 1'b1};
                  end else begin
                     m = mn;
                     q = {q[RW-2:0], 1'b0};
                  end
               end
            end
            rad_in[s][l]  = r;
            rem_in[s][l]  = m;
            root_in[s][l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (rdy[s]) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            set_ff[s]  <= (s == 0) ? in_set : set_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   assign out_set   = set_ff[NS-1];
   assign out_ortho = root_ff[NS-1][0];
   assign out_diag  = root_ff[NS-1][1];

endmodule

// File: rtl/cbz_emit.sv
// Output stage: holds one point and issues its four pixel writes in order.
module cbz_emit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  cbz_pkg::pix_set_type                in_set,
   input  logic [cbz_pkg::INTEN_BITS-1:0]      in_ortho,
   input  logic [cbz_pkg::INTEN_BITS-1:0]      in_diag,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [cbz_pkg::PIX_BITS-1:0]        out_x,
   output logic [cbz_pkg::PIX_BITS-1:0]        out_y,
   output logic [cbz_pkg::INTEN_BITS-1:0]      out_inten,
   output logic                                out_blend,
   output logic                                out_last
);

   localparam logic [1:0] WR_CENTER = 2'd0;
   localparam logic [1:0] WR_HORIZ  = 2'd1;
   localparam logic [1:0] WR_VERT   = 2'd2;
   localparam logic [1:0] WR_DIAG   = 2'd3;

   logic                             hold_v_ff;
   logic [1:0]                       cnt_ff;
   cbz_pkg::pix_set_type             set_ff;
   logic [cbz_pkg::INTEN_BITS-1:0]   ortho_ff, diag_ff;

   assign in_ready  = !hold_v_ff || (out_ready && cnt_ff == WR_DIAG);
   assign out_valid = hold_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff    <= WR_CENTER;
      end else begin
         if (hold_v_ff && out_ready) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
         if (in_ready) begin
            hold_v_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         set_ff   <= in_set;
         ortho_ff <= in_ortho;
         diag_ff  <= in_diag;
      end
   end

   always_comb begin
      unique case (cnt_ff)
         WR_CENTER: begin
            out_x     = set_ff.ix;
            out_y     = set_ff.iy;
            out_inten = cbz_pkg::INTEN_FULL;
            out_blend = 1'b0;
            out_last  = 1'b0;
         end
         WR_HORIZ: begin
            out_x     = set_ff.nx;
            out_y     = set_ff.iy;
            out_inten = ortho_ff;
            out_blend = 1'b1;
            out_last  = 1'b0;
         end
         WR_VERT: begin
            out_x     = set_ff.ix;
            out_y     = set_ff.ny;
            out_inten = ortho_ff;
            out_blend = 1'b1;
            out_last  = 1'b0;
         end
         WR_DIAG: begin
            out_x     = set_ff.nx;
            out_y     = set_ff.ny;
            out_inten = diag_ff;
            out_blend = 1'b1;
            out_last  = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/cubic_bezier_antialiased_plotter.sv
// Top level of the anti-aliased cubic Bezier plotter with its register port.
//
// Usage: program the four control points (p0..p3, x and y, pixel units) over
// the csr_ port while the block is idle. Each item on the req_ stream is a
// curve parameter t in unsigned Q1.12 (4096 is t = 1, larger values clamp).
// Every lerp weights the first point by t, so t = 1 lands on p0.
// For each item the rsp_ stream carries four pixel writes: the pixel that
// holds the point at full intensity (tuser low, overwrite), then the
// horizontal, vertical and diagonal neighbors toward the nearer half with
// tuser high (max-blend). Neighbors get 255*d, the diagonal 255*d/sqrt2,
// where d is the distance to the pixel center. tlast marks the diagonal.
// The path is seven stages of de Casteljau lerps, three of distance math, a
// root pipeline that resolves two result bits per stage, and the output register.
// Throughput: the pipeline takes one item per cycle until it is full; after
// that it takes a new item only as the last of the four writes of the item
// before is taken, since the four writes share the single result channel.
// A stalled receiver holds the current write steady and backs the pipeline
// up stage by stage; nothing is lost. Reset clears all pipeline valid bits
// and sets every control point to 0.
module cubic_bezier_antialiased_plotter #(
   parameter int COORD_BITS  = cbz_pkg::COORD_BITS_DEF,
   parameter int T_FRAC_BITS = cbz_pkg::T_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((T_FRAC_BITS+8)/8)*8-1:0]     req_tdata,  // [T_FRAC_BITS:0] t_frac
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbz_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // pix_x, pix_y, intensity
   output logic                                 rsp_tuser,  // blend_max
   output logic                                 rsp_tlast,  // last_write
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cbz_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [cbz_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [cbz_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int F  = T_FRAC_BITS;
   localparam int P  = COORD_BITS + F;
   localparam int W  = 2 * F + cbz_pkg::GAIN_BITS;
   localparam int RW = W / 2;
   localparam int PB = cbz_pkg::PIX_BITS;
   localparam int IB = cbz_pkg::INTEN_BITS;

   // Control point registers, addressed by word.
   logic [COORD_BITS-1:0]             cp_ff [cbz_pkg::NUM_REGS];
   logic [cbz_pkg::REG_IDX_BITS-1:0]  csr_idx;
   logic                              csr_wr;
   logic [COORD_BITS-1:0]             cp_x [4];
   logic [COORD_BITS-1:0]             cp_y [4];

   assign csr_idx    = csr_paddr[cbz_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = cbz_pkg::CSR_DATA_BITS'(cp_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbz_pkg::NUM_REGS; i++) begin
            cp_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         cp_ff[csr_idx] <= csr_pwdata[COORD_BITS-1:0];
      end
   end

   assign cp_x[0] = cp_ff[cbz_pkg::REG_P0_X];
   assign cp_y[0] = cp_ff[cbz_pkg::REG_P0_Y];
   assign cp_x[1] = cp_ff[cbz_pkg::REG_P1_X];
   assign cp_y[1] = cp_ff[cbz_pkg::REG_P1_Y];
   assign cp_x[2] = cp_ff[cbz_pkg::REG_P2_X];
   assign cp_y[2] = cp_ff[cbz_pkg::REG_P2_Y];
   assign cp_x[3] = cp_ff[cbz_pkg::REG_P3_X];
   assign cp_y[3] = cp_ff[cbz_pkg::REG_P3_Y];

   // Curve point pipeline.
   logic                 crv_valid, crv_ready;
   logic [P-1:0]         crv_px, crv_py;

   cbz_curve #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_curve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_t      (req_tdata[F:0]),
      .cp_x      (cp_x),
      .cp_y      (cp_y),
      .out_valid (crv_valid),
      .out_ready (crv_ready),
      .out_px    (crv_px),
      .out_py    (crv_py)
   );

   // Neighbor choice and squared distance.
   logic                 dst_valid, dst_ready;
   cbz_pkg::pix_set_type dst_set;
   logic [W-1:0]         dst_w;

   cbz_dist #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (crv_valid),
      .in_ready  (crv_ready),
      .in_px     (crv_px),
      .in_py     (crv_py),
      .out_valid (dst_valid),
      .out_ready (dst_ready),
      .out_set   (dst_set),
      .out_w     (dst_w)
   );

   // Square roots for the neighbor intensities.
   logic                 rt_valid, rt_ready;
   cbz_pkg::pix_set_type rt_set;
   logic [RW-1:0]        rt_ortho, rt_diag;

   cbz_root #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dst_valid),
      .in_ready  (dst_ready),
      .in_set    (dst_set),
      .in_w      (dst_w),
      .out_valid (rt_valid),
      .out_ready (rt_ready),
      .out_set   (rt_set),
      .out_ortho (rt_ortho),
      .out_diag  (rt_diag)
   );

   // The root keeps F fraction bits; the integer part is the intensity.
   logic [PB-1:0] emt_x, emt_y;
   logic [IB-1:0] emt_inten;

   cbz_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_ready  (rt_ready),
      .in_set    (rt_set),
      .in_ortho  (rt_ortho[RW-1:F]),
      .in_diag   (rt_diag[RW-1:F]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (emt_x),
      .out_y     (emt_y),
      .out_inten (emt_inten),
      .out_blend (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {emt_inten, emt_y, emt_x};

`ifndef SYNTH
   // Only the diagonal write closes an item, and it always blends.
   a_last_blends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last write of an item is not a blend write");

   // The center write is an overwrite at full intensity and never the last.
   a_center_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[2*PB+IB-1:2*PB] == cbz_pkg::INTEN_FULL && !rsp_tlast)
      else $error("center write lacks full intensity");

   // After the center write the horizontal neighbor follows at once, same row.
   a_horiz_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tuser |=>
         rsp_tvalid && rsp_tuser && rsp_tdata[2*PB-1:PB] == $past(rsp_tdata[2*PB-1:PB]))
      else $error("horizontal neighbor write did not follow the center write");
`endif

endmodule
